FILE: src/efe_pkg.sv
// Shared types, byte codes and escape helpers for the escaped XOR frame encoder.
// No dependencies; every other file in src uses this package.
`timescale 1ns / 1ps

package efe_pkg;

    // Framing byte codes
    localparam logic [7:0] FLAG_BYTE    = 8'h7e;
    localparam logic [7:0] ESC_BYTE     = 8'h7d;
    localparam logic [7:0] ESC_FOR_FLAG = 8'h02;
    localparam logic [7:0] ESC_FOR_ESC  = 8'h01;

    // One classified input byte, ready for the output sequencer
    typedef struct packed {
        logic       add_open;   // frame not yet open: send opening flag first
        logic [7:0] data;       // raw byte, or escape prefix source
        logic       data_esc;   // data needs a two-byte escape
        logic [7:0] data_sub;   // second byte of the data escape
        logic       last;       // final byte: append check and closing flag
        logic [7:0] check;      // XOR check including this byte
        logic       check_esc;  // check needs a two-byte escape
        logic [7:0] check_sub;  // second byte of the check escape
    } job_t;

    // Frame tracking state of the front end
    typedef struct packed {
        logic       in_frame;
        logic [7:0] check;
    } front_status_t;

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] escape_code(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FOR_FLAG : ESC_FOR_ESC;
    endfunction

endpackage

FILE: src/escaped_xor_frame_encoder_top.sv
// Top level of the escaped XOR frame encoder: front end, job queue, output sequencer.
// Depends on efe_pkg, efe_front, efe_queue and efe_back.
`timescale 1ns / 1ps

// Usage
//   Slave side: one raw message byte per beat on s_tdata, s_tlast on the final
//   byte of a message. Master side: the framed stream, one byte per beat, with
//   m_tlast on the last output beat caused by an input beat and m_tuser[0] on
//   the closing 0x7e flag of each frame.
//   Each input beat produces 1 to 6 output beats: an opening flag on the first
//   byte of a message, one beat for a plain byte or two for an escaped one, and
//   on the final byte one or two check beats plus the closing flag.
//   When the queue is empty, an accepted input is first written into the
//   queue, then its first output beat is loaded into the output register.
//   Throughput: the output sequencer emits one beat per cycle while a job is
//   queued and the receiver does not stall; a job leaves the queue with its
//   last output beat, so an input holds the queue head until all are sent.
//   The front end keeps accepting while the job queue (QUEUE_DEPTH entries)
//   has room; when the receiver stalls, the output register holds its beat,
//   the queue fills and s_tready falls.
//   Reset (aresetn low, synchronous) closes any open frame, clears the check,
//   empties the queue and drops m_tvalid.

module escaped_xor_frame_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // run_last
    output logic [0:0] m_tuser    // [0] frame_end
);

    efe_pkg::job_t          push_job;
    efe_pkg::job_t          head_job;
    efe_pkg::front_status_t front_status;
    logic                   push;
    logic                   queue_full;
    logic                   head_valid;
    logic                   pop;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && s_tready;

    efe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (push),
        .data_byte      (s_tdata),
        .end_of_message (s_tlast),
        .job            (push_job),
        .status         (front_status)
    );

    efe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    efe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // A closing beat is always the flag byte and ends its run
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata == efe_pkg::FLAG_BYTE))
        else $error("closing beat is not a final flag byte");

    // With no frame open the running check is clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        !front_status.in_frame |-> (front_status.check == 8'h00))
        else $error("check not cleared outside a frame");

    // A job is popped from the queue only when the sequencer loads a run end
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_tvalid && m_tlast))
        else $error("job retired without a final beat");

    // The output register comes out of reset empty
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: src/efe_front.sv
// Front end: tracks the open frame and the running XOR, classifies each input beat.
// Depends on efe_pkg.
`timescale 1ns / 1ps

module efe_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  end_of_message,
    output efe_pkg::job_t         job,
    output efe_pkg::front_status_t status
);

    logic       in_frame_reg, in_frame_next;
    logic [7:0] check_reg, check_next;
    logic [7:0] check_new;

    // Fold this byte into the check
    assign check_new = check_reg ^ data_byte;

    // Build the job descriptor
    always_comb begin
        job.add_open  = !in_frame_reg;
        job.data      = data_byte;
        job.data_esc  = efe_pkg::needs_escape(data_byte);
        job.data_sub  = efe_pkg::escape_code(data_byte);
        job.last      = end_of_message;
        job.check     = check_new;
        job.check_esc = efe_pkg::needs_escape(check_new);
        job.check_sub = efe_pkg::escape_code(check_new);
    end

    // Advance frame state on each accepted beat; close and clear on the final byte
    always_comb begin
        in_frame_next = in_frame_reg;
        check_next    = check_reg;
        if (accept) begin
            in_frame_next = !end_of_message;
            check_next    = end_of_message ? 8'h00 : check_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            check_reg    <= 8'h00;
        end else begin
            in_frame_reg <= in_frame_next;
            check_reg    <= check_next;
        end
    end

    assign status.in_frame = in_frame_reg;
    assign status.check    = check_reg;

endmodule

FILE: src/efe_queue.sv
// Short job queue between front end and output sequencer.
// Depends on efe_pkg for the job type.
`timescale 1ns / 1ps

module efe_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  efe_pkg::job_t push_job,
    output logic          full,
    output logic          head_valid,
    output efe_pkg::job_t head_job,
    input  logic          pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    efe_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload; no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/efe_back.sv
// Output sequencer: expands the head job into framed, escaped output beats.
// Depends on efe_pkg; drives the registered master-side stream.
`timescale 1ns / 1ps

module efe_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          head_valid,
    input  efe_pkg::job_t head_job,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tlast,
    output logic [0:0]    m_tuser
);

    typedef enum logic [2:0] {
        ST_START,
        ST_OPEN,
        ST_DATA,
        ST_DATA2,
        ST_CHECK,
        ST_CHECK2,
        ST_CLOSE
    } step_t;

    step_t      state_reg, state_next;
    step_t      cur_step, after_step;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       m_tuser_reg, m_tuser_next;
    logic       emit;
    logic       job_done;
    logic [7:0] beat_byte;
    logic       beat_end;

    // Load a beat when the output register is free or being drained
    assign emit = head_valid && (!m_tvalid_reg || m_tready);

    // Resolve the first step of a fresh job
    always_comb begin
        if (state_reg == ST_START) begin
            cur_step = head_job.add_open ? ST_OPEN : ST_DATA;
        end else begin
            cur_step = state_reg;
        end
    end

    // Decode the current step into a beat and the following step
    always_comb begin
        beat_byte  = efe_pkg::FLAG_BYTE;
        beat_end   = 1'b0;
        job_done   = 1'b0;
        after_step = ST_START;
        unique case (cur_step)
            ST_OPEN: begin
                beat_byte  = efe_pkg::FLAG_BYTE;
                after_step = ST_DATA;
            end
            ST_DATA: begin
                beat_byte = head_job.data_esc ? efe_pkg::ESC_BYTE : head_job.data;
                if (head_job.data_esc) begin
                    after_step = ST_DATA2;
                end else if (head_job.last) begin
                    after_step = ST_CHECK;
                end else begin
                    job_done = 1'b1;
                end
            end
            ST_DATA2: begin
                beat_byte = head_job.data_sub;
                if (head_job.last) begin
                    after_step = ST_CHECK;
                end else begin
                    job_done = 1'b1;
                end
            end
            ST_CHECK: begin
                beat_byte  = head_job.check_esc ? efe_pkg::ESC_BYTE : head_job.check;
                after_step = head_job.check_esc ? ST_CHECK2 : ST_CLOSE;
            end
            ST_CHECK2: begin
                beat_byte  = head_job.check_sub;
                after_step = ST_CLOSE;
            end
            ST_CLOSE: begin
                beat_byte = efe_pkg::FLAG_BYTE;
                beat_end  = 1'b1;
                job_done  = 1'b1;
            end
            default: begin
                beat_byte = efe_pkg::FLAG_BYTE;
            end
        endcase
    end

    assign pop = emit && job_done;

    // Next state and output register
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (emit) begin
            state_next    = job_done ? ST_START : after_step;
            m_tvalid_next = 1'b1;
            m_tdata_next  = beat_byte;
            m_tlast_next  = job_done;
            m_tuser_next  = beat_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_START;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
